### hw/rtl/gmps_pkg.sv
// Shared constants for the grid minimum path sum block.
// Used by gmps_cell, gmps_chain and grid_min_path_sum; depends on nothing.
package gmps_pkg;

    // Field widths.
    localparam int VALUE_W    = 16;
    localparam int COST_W     = 27;
    localparam int ROWS_W     = 11;
    localparam int COLS_W     = 9;

    // Stream data widths, rounded up to whole bytes.
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 32;

    // Configuration port.
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 11;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_ROWS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_COLS = CFG_INDEX_W'(1);

    // Saturation limit of a cost.
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // Default grid limits.
    localparam int DEF_MAX_COLS = 256;
    localparam int DEF_MAX_ROWS = 1024;

endpackage

### hw/rtl/gmps_cell.sv
// One storage cell of the column cost line.
// Depends on gmps_pkg for the cost width.
module gmps_cell (
    input  logic                      clk,
    input  logic                      shift,
    input  logic                      load,
    input  logic [gmps_pkg::COST_W-1:0] new_cost,
    input  logic [gmps_pkg::COST_W-1:0] prev_cost,
    output logic [gmps_pkg::COST_W-1:0] cost
);
    import gmps_pkg::*;

    logic [COST_W-1:0] cost_reg;
    logic [COST_W-1:0] cost_next;

    // Take the fresh cost at the insertion point, otherwise the neighbor's.
    always_comb
    begin
        cost_next = load ? new_cost : prev_cost;
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            cost_reg <= cost_next;
        end
    end

    assign cost = cost_reg;

endmodule

### hw/rtl/gmps_chain.sv
// Row of cost cells that delays each cell cost by one grid row.
// Depends on gmps_pkg and gmps_cell.
module gmps_chain #(
    parameter int MAX_COLS = gmps_pkg::DEF_MAX_COLS,
    parameter int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                        clk,
    input  logic                        shift,
    input  logic [COL_W-1:0]            ins_point,
    input  logic [gmps_pkg::COST_W-1:0] new_cost,
    output logic [gmps_pkg::COST_W-1:0] up_cost
);
    import gmps_pkg::*;

    logic [COST_W-1:0] cell_cost [MAX_COLS];

    // A cost enters at the insertion point and reaches the last cell after
    // as many shifts as the grid has columns, just in time for the cell below.
    for (genvar k = 0; k < MAX_COLS; k++)
    begin : g_cell
        logic [COST_W-1:0] prev;

        if (k == 0)
        begin : g_first
            assign prev = new_cost;
        end
        else
        begin : g_rest
            assign prev = cell_cost[k-1];
        end

        gmps_cell u_cell (
            .clk       (clk),
            .shift     (shift),
            .load      (ins_point == COL_W'(k)),
            .new_cost  (new_cost),
            .prev_cost (prev),
            .cost      (cell_cost[k])
        );
    end

    assign up_cost = cell_cost[MAX_COLS-1];

endmodule

### hw/rtl/grid_min_path_sum.sv
// Top level of the grid minimum path sum block: control, arithmetic and output.
// Depends on gmps_pkg and gmps_chain.
//
// Usage: grid cells arrive on the s_ channel in row-major order, one 16-bit
// value per request. For each cell one request leaves on the m_ channel with
// the minimum right/down path cost from the top-left cell in m_tdata; m_tlast
// marks the bottom-right cell, whose cost is the answer. The next cell after
// that starts a new grid.
// The grid size is written on the cfg_ channel (index 0 rows, index 1 columns,
// zero reads as one, large values saturate); cfg_ready is always high and any
// write restarts the grid. Write only while no request is in flight.
// The result is registered in the output stage. Throughput is one cell per
// cycle while s_tready is high: each cell needs one compare and one saturating
// add on the left cost and the row-above cost, which the cell chain delivers.
// A two-entry output stage (output register plus skid register) lets one more
// cell be accepted while a result waits; s_tready drops only when both hold
// results. Reset empties the output stage, sets both sizes to one and starts
// at the top-left cell; stored column costs need no clearing because the
// first row rewrites them.
module grid_min_path_sum #(
    parameter int MAX_COLS = gmps_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = gmps_pkg::DEF_MAX_ROWS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input cells.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [gmps_pkg::S_TDATA_W-1:0]      s_tdata,   // [15:0] cell_value
    // Output costs.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gmps_pkg::M_TDATA_W-1:0]      m_tdata,   // [26:0] cell_cost, rest zero
    output logic                                m_tlast,   // is_final
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gmps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gmps_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import gmps_pkg::*;

    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // Grid position and size.
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  cols_last_reg, cols_last_next;
    logic [ROW_W-1:0]  rows_last_reg, rows_last_next;
    logic [COST_W-1:0] left_reg, left_next;

    // Output stage.
    logic              out_valid_reg, out_valid_next;
    logic [COST_W-1:0] out_cost_reg, out_cost_next;
    logic              out_last_reg, out_last_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [COST_W-1:0] skid_cost_reg, skid_cost_next;
    logic              skid_last_reg, skid_last_next;

    logic              cfg_write;
    logic              s_accept;
    logic [COST_W-1:0] up_cost;
    logic [COST_W-1:0] base_cost;
    logic [COST_W:0]   sum;
    logic [COST_W-1:0] cost;
    logic              is_final;
    logic              row_end;
    logic [31:0]       size_in;
    logic [31:0]       size_eff;
    logic [COL_W-1:0]  ins_point;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;
    assign s_tready  = ~skid_valid_reg;
    assign s_accept  = s_tvalid & s_tready;

    // Row delay line of column costs.
    assign ins_point = COL_W'(MAX_COLS - 1) - cols_last_reg;

    gmps_chain #(
        .MAX_COLS (MAX_COLS),
        .COL_W    (COL_W)
    ) u_chain (
        .clk       (clk),
        .shift     (s_accept),
        .ins_point (ins_point),
        .new_cost  (cost),
        .up_cost   (up_cost)
    );

    // Cell cost: pick the predecessor, then add with saturation.
    always_comb
    begin
        if (row_reg == '0 && col_reg == '0)
        begin
            base_cost = '0;
        end
        else if (row_reg == '0)
        begin
            base_cost = left_reg;
        end
        else if (col_reg == '0)
        begin
            base_cost = up_cost;
        end
        else
        begin
            base_cost = (up_cost < left_reg) ? up_cost : left_reg;
        end
        sum      = {1'b0, base_cost} + (COST_W+1)'(s_tdata[VALUE_W-1:0]);
        cost     = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
        row_end  = (col_reg == cols_last_reg);
        is_final = row_end && (row_reg == rows_last_reg);
    end

    // Effective size of a configuration write, before conversion to a last index.
    always_comb
    begin
        if (cfg_index == REG_NUM_ROWS)
        begin
            size_in = 32'(cfg_data[ROWS_W-1:0]);
            if (size_in == 32'd0)
            begin
                size_eff = 32'd1;
            end
            else if (size_in > 32'(MAX_ROWS))
            begin
                size_eff = 32'(MAX_ROWS);
            end
            else
            begin
                size_eff = size_in;
            end
        end
        else
        begin
            size_in = 32'(cfg_data[COLS_W-1:0]);
            if (size_in == 32'd0)
            begin
                size_eff = 32'd1;
            end
            else if (size_in > 32'(MAX_COLS))
            begin
                size_eff = 32'(MAX_COLS);
            end
            else
            begin
                size_eff = size_in;
            end
        end
    end

    // Position, size and left cost updates.
    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        left_next      = left_reg;
        cols_last_next = cols_last_reg;
        rows_last_next = rows_last_reg;
        if (cfg_write)
        begin
            col_next  = '0;
            row_next  = '0;
            left_next = '0;
            case (cfg_index)
                REG_NUM_ROWS: rows_last_next = ROW_W'(size_eff - 32'd1);
                REG_NUM_COLS: cols_last_next = COL_W'(size_eff - 32'd1);
                default: ;
            endcase
        end
        else if (s_accept)
        begin
            left_next = cost;
            if (is_final)
            begin
                col_next  = '0;
                row_next  = '0;
                left_next = '0;
            end
            else if (row_end)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // Output register with skid register behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_cost_next   = out_cost_reg;
        out_last_next   = out_last_reg;
        skid_valid_next = skid_valid_reg;
        skid_cost_next  = skid_cost_reg;
        skid_last_next  = skid_last_reg;
        if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_cost_next   = skid_cost_reg;
                out_last_next   = skid_last_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (s_accept)
        begin
            if (!out_valid_reg || m_tready)
            begin
                out_valid_next = 1'b1;
                out_cost_next  = cost;
                out_last_next  = is_final;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_cost_next  = cost;
                skid_last_next  = is_final;
            end
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            left_reg       <= '0;
            cols_last_reg  <= '0;
            rows_last_reg  <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            left_reg       <= left_next;
            cols_last_reg  <= cols_last_next;
            rows_last_reg  <= rows_last_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_cost_reg  <= out_cost_next;
        out_last_reg  <= out_last_next;
        skid_cost_reg <= skid_cost_next;
        skid_last_reg <= skid_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_cost_reg);
    assign m_tlast  = out_last_reg;

    // The skid register only fills behind a waiting output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result with the output register empty");

    // The column never runs past the configured width.
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= cols_last_reg)
        else $error("column position beyond grid width");

    // The row never runs past the configured height.
    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= rows_last_reg)
        else $error("row position beyond grid height");

    // After the bottom-right cell the next grid starts at the top-left cell.
    a_restart_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && is_final) |=> (col_reg == '0 && row_reg == '0 && left_reg == '0))
        else $error("grid did not restart after the final cell");

endmodule
